// ----- rtl/core/tbl_pkg.sv -----
// Shared types, constants and character classes for the token boundary lexer.
package tbl_pkg;

  // Width of the lexeme length counter. The counter saturates at its all-ones value.
  localparam int LEN_W = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Depth of the result queue. It must hold at least two more results than
  // the fill level at which the input side stalls.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_START      = 5'd0,
    ST_IDENT      = 5'd1,
    ST_INT        = 5'd2,
    ST_FLOAT      = 5'd3,
    ST_STRING     = 5'd4,
    ST_ESCAPE     = 5'd5,
    ST_SLASH      = 5'd8,
    ST_LINE_COMM  = 5'd9,
    ST_BLOCK_COMM = 5'd10,
    ST_BLOCK_STAR = 5'd11,
    ST_ASSIGN_OP  = 5'd13,
    ST_REPEAT_OP  = 5'd14,
    ST_DASH       = 5'd15,
    ST_OP_DONE    = 5'd17
  } lex_state_t;

  typedef enum logic [2:0] {
    KIND_OPER    = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_INT     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_COMMENT = 3'd5,
    KIND_ERROR   = 3'd6
  } tok_kind_t;

  // One finished token as it leaves the block.
  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  len;
    logic [7:0]  first;
    logic        last;
  } tok_res_t;

  // Everything the step logic hands back for one accepted request.
  typedef struct packed {
    tok_res_t          res0;
    tok_res_t          res1;
    logic [1:0]        count;
    lex_state_t        state;
    logic [7:0]        first;
    logic [LEN_W-1:0]  len;
  } step_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  // Reported length: the counter value, clipped to what eight bits can show.
  function automatic logic [7:0] out_len(input logic [LEN_W-1:0] len);
    logic [15:0] wide;
    wide = 16'(len);
    return (wide > 16'd255) ? 8'hFF : wide[7:0];
  endfunction

  // State entered from the start state on a character. ST_START means the
  // character opens no token; ST_OP_DONE marks a one-character operator.
  function automatic lex_state_t start_next(input logic [7:0] c);
    lex_state_t nxt;
    if (is_alpha(c) || c == "_") begin
      nxt = ST_IDENT;
    end else if (is_digit(c)) begin
      nxt = ST_INT;
    end else if (c == "'" || c == "\"") begin
      nxt = ST_STRING;
    end else if (c == "/") begin
      nxt = ST_SLASH;
    end else if (c inside {"{", "}", "[", "]", "(", ")", ".", ",", ":", ";", "~"}) begin
      nxt = ST_OP_DONE;
    end else if (c inside {"^", "!", "*", "%", "="}) begin
      nxt = ST_ASSIGN_OP;
    end else if (c inside {"&", "|", "+", "<", ">"}) begin
      nxt = ST_REPEAT_OP;
    end else if (c == "-") begin
      nxt = ST_DASH;
    end else begin
      nxt = ST_START;
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/core/tbl_step.sv -----
// Combinational automaton step: next state and up to two finished tokens.
module tbl_step (
  input  tbl_pkg::lex_state_t             state,
  input  logic [7:0]                      first_char,
  input  logic [tbl_pkg::LEN_W-1:0]       lexeme_len,
  input  logic [7:0]                      char_code,
  input  logic                            end_of_input,
  output tbl_pkg::step_out_t              step
);
  import tbl_pkg::*;

  logic [LEN_W-1:0] grown;
  logic             fin0;
  logic             fin1;
  logic             rerun;
  tok_kind_t        kind0;
  lex_state_t       f_state;
  lex_state_t       s_next;
  logic [7:0]       f_first;
  logic [LEN_W-1:0] f_len;
  tok_res_t         r0;
  tok_res_t         r1;

  assign grown  = (lexeme_len < LEN_MAX) ? lexeme_len + LEN_W'(1) : lexeme_len;
  assign s_next = start_next(char_code);

  always_comb begin
    fin0    = 1'b0;
    fin1    = 1'b0;
    rerun   = 1'b0;
    kind0   = KIND_OPER;
    f_state = state;
    f_first = first_char;
    f_len   = lexeme_len;

    if (end_of_input) begin
      if (state != ST_START) begin
        fin0  = 1'b1;
        kind0 = KIND_ERROR;
      end
      f_state = ST_START;
      f_len   = '0;
    end else begin
      case (state)
        ST_IDENT: begin
          if (is_alpha(char_code) || is_digit(char_code) || char_code == "_") begin
            f_len = grown;
          end else begin
            fin0 = 1'b1; kind0 = KIND_IDENT; rerun = 1'b1;
          end
        end
        ST_INT: begin
          if (char_code == ".") begin
            f_len = grown; f_state = ST_FLOAT;
          end else if (is_digit(char_code)) begin
            f_len = grown;
          end else begin
            fin0 = 1'b1; kind0 = KIND_INT; rerun = 1'b1;
          end
        end
        ST_FLOAT: begin
          if (is_digit(char_code)) begin
            f_len = grown;
          end else begin
            fin0 = 1'b1; kind0 = KIND_FLOAT; rerun = 1'b1;
          end
        end
        ST_STRING: begin
          if (char_code == "\\") begin
            f_len = grown; f_state = ST_ESCAPE;
          end else if (char_code == "'" || char_code == "\"") begin
            fin0 = 1'b1; kind0 = KIND_STRING;
          end else begin
            f_len = grown;
          end
        end
        ST_ESCAPE: begin
          f_len = grown; f_state = ST_STRING;
        end
        ST_SLASH: begin
          if (char_code == "/") begin
            f_len = grown; f_state = ST_LINE_COMM;
          end else if (char_code == "*") begin
            f_len = grown; f_state = ST_BLOCK_COMM;
          end else begin
            fin0 = 1'b1; kind0 = KIND_OPER; rerun = 1'b1;
          end
        end
        ST_LINE_COMM: begin
          if (char_code == "\n") begin
            fin0 = 1'b1; kind0 = KIND_COMMENT;
          end else begin
            f_len = grown;
          end
        end
        ST_BLOCK_COMM: begin
          f_len = grown;
          if (char_code == "*") begin
            f_state = ST_BLOCK_STAR;
          end
        end
        ST_BLOCK_STAR: begin
          if (char_code == "/") begin
            fin0 = 1'b1; kind0 = KIND_COMMENT;
          end else begin
            f_len = grown;
            if (char_code != "*") begin
              f_state = ST_BLOCK_COMM;
            end
          end
        end
        ST_ASSIGN_OP: begin
          if (char_code == "=") begin
            f_len = grown; f_state = ST_OP_DONE;
          end else begin
            fin0 = 1'b1; kind0 = KIND_OPER; rerun = 1'b1;
          end
        end
        ST_REPEAT_OP: begin
          if (char_code == "=" || char_code == first_char) begin
            f_len = grown; f_state = ST_OP_DONE;
          end else begin
            fin0 = 1'b1; kind0 = KIND_OPER; rerun = 1'b1;
          end
        end
        ST_DASH: begin
          if (char_code == "-" || char_code == "=" || char_code == ">") begin
            f_len = grown; f_state = ST_OP_DONE;
          end else begin
            fin0 = 1'b1; kind0 = KIND_OPER; rerun = 1'b1;
          end
        end
        ST_OP_DONE: begin
          fin0 = 1'b1; kind0 = KIND_OPER; rerun = 1'b1;
        end
        default: begin
          rerun = 1'b1;
        end
      endcase

      if (fin0) begin
        f_state = ST_START;
        f_len   = '0;
      end

      // The closing character is run again from the start state.
      if (rerun) begin
        if (s_next == ST_START) begin
          f_state = ST_START;
          f_len   = '0;
        end else begin
          f_first = char_code;
          if (s_next == ST_OP_DONE) begin
            fin1    = 1'b1;
            f_state = ST_START;
            f_len   = '0;
          end else begin
            f_state = s_next;
            f_len   = LEN_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    r0.kind  = kind0;
    r0.len   = out_len(lexeme_len);
    r0.first = first_char;
    r0.last  = !fin1;

    r1.kind  = KIND_OPER;
    r1.len   = out_len(LEN_W'(1));
    r1.first = char_code;
    r1.last  = 1'b1;

    step.state = f_state;
    step.first = f_first;
    step.len   = f_len;
    if (fin0 && fin1) begin
      step.res0  = r0;
      step.res1  = r1;
      step.count = 2'd2;
    end else if (fin1) begin
      step.res0  = r1;
      step.res1  = r1;
      step.count = 2'd1;
    end else begin
      step.res0  = r0;
      step.res1  = r1;
      step.count = {1'b0, fin0};
    end
  end

endmodule

// ----- rtl/core/tbl_outq.sv -----
// Small result queue that takes up to two tokens a cycle and releases one while out_stall is low.
module tbl_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  tbl_pkg::tok_res_t     push0,
  input  tbl_pkg::tok_res_t     push1,
  output logic                  full_for_two,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tbl_pkg::tok_res_t     head
);
  import tbl_pkg::*;

  tok_res_t         entries [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic [Q_CW-1:0]  count_next;
  logic             pop;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = (count != '0);
  assign head         = entries[rd_ptr];
  // Stall the writer unless room for two results is certain.
  assign full_for_two = (count > Q_CW'(Q_DEPTH - 2));
  assign count_next   = count + Q_CW'(push_count) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push_count);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + Q_AW'(1)] <= push1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("result queue over-filled");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == Q_CW'(Q_DEPTH)) || (Q_AW'(wr_ptr - rd_ptr) == count[Q_AW-1:0]))
    else $error("queue pointers disagree with fill count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full_for_two |-> (count_next <= Q_CW'(Q_DEPTH)))
    else $error("queue would overflow");

endmodule

// ----- rtl/core/token_boundary_lexer.sv -----
// Top level of the token boundary lexer: automaton state and request channels.
//
// The block takes one character request per cycle on the input channel
// (char_code with end_of_input) and returns finished tokens on the output
// channel (token_kind, token_length, token_first_char, last_of_run). A request
// is taken at a rising edge where its valid is high and its stall is low.
//
// Each input request is applied to the automaton state in the cycle it is
// accepted; the tokens it closes (none, one or two) enter a four-entry result
// queue and the first of them is offered once the tokens ahead of it have been
// taken. Throughput is one character per cycle for as long as the receiver
// drains one token per cycle; a request that closes two tokens (a token ended
// by a one-character operator) hands the receiver both in turn, and the queue
// absorbs that. in_stall rises only when the queue could not take two more
// tokens, which happens when the receiver stalls out_stall.
// last_of_run marks the final token caused by one input request.
//
// Synchronous reset returns the automaton to its start state with a zero
// length and clears the queue; a stalled token stays stable on the outputs.
module token_boundary_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [7:0]  token_length,
  output logic [7:0]  token_first_char,
  output logic        last_of_run
);
  import tbl_pkg::*;

  lex_state_t        state;
  logic [7:0]        first_char;
  logic [LEN_W-1:0]  lexeme_len;
  step_out_t         step;
  tok_res_t          head;
  logic              accept;
  logic [1:0]        push_count;

  assign accept     = in_valid && !in_stall;
  assign push_count = accept ? step.count : 2'd0;

  // The automaton step itself: pure logic on the current state and character.
  tbl_step u_step (
    .state        (state),
    .first_char   (first_char),
    .lexeme_len   (lexeme_len),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .step         (step)
  );

  // Finished tokens wait here so that the input side keeps moving while the
  // receiver holds a token.
  tbl_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push0        (step.res0),
    .push1        (step.res1),
    .full_for_two (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .head         (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      first_char <= '0;
      lexeme_len <= '0;
    end else if (accept) begin
      state      <= step.state;
      first_char <= step.first;
      lexeme_len <= step.len;
    end
  end

  assign token_kind       = head.kind;
  assign token_length     = head.len;
  assign token_first_char = head.first;
  assign last_of_run      = head.last;

  a_eoi_to_start: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> state == ST_START)
    else $error("end marker did not return the automaton to its start state");

  a_start_len_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_START |-> lexeme_len == '0)
    else $error("start state holds a non-zero lexeme length");

  a_stall_has_tokens: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled while no token is waiting");

  a_two_results_op: assert property (@(posedge clk) disable iff (rst)
    accept && step.count == 2'd2 |-> step.res1.kind == KIND_OPER && !step.res0.last)
    else $error("second token of a request is not a closing operator");

endmodule
